// ----- src/lru_key_value_cache_unit_macros.svh -----
// Assertion macros shared by the cache RTL
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define LRUC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LRUC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LRUC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/lruc_pkg.sv -----
// Types and constants shared by the LRU key-value cache
package lruc_pkg;

    localparam int ENTRIES   = 8;
    localparam int SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W     = $clog2(ENTRIES + 1);
    localparam int CFG_W     = 4;
    localparam int CMP_W     = (CFG_W > OCC_W) ? CFG_W : OCC_W;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [SLOT_W-1:0] rank_t;
    typedef logic [OCC_W-1:0]  occ_t;
    typedef logic [CFG_W-1:0]  cfg_t;
    typedef logic [CMP_W-1:0]  cmp_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [VAL_W-1:0]  val_t;

    localparam slot_t LAST_SLOT = slot_t'(ENTRIES - 1);
    localparam cfg_t  CAP_RESET = cfg_t'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Outcome of one pass over all slots
    typedef struct packed {
        logic  found;
        slot_t found_idx;
        rank_t found_rank;
        val_t  found_value;
        logic  lru_ok;
        slot_t lru_idx;
        rank_t lru_rank;
        key_t  lru_key;
        logic  free_ok;
        slot_t free_idx;
    } scan_res_t;

endpackage

// ----- src/lruc_scan.sv -----
// Shared compare unit: visits one slot a cycle while step is high, tracks match, LRU victim and free slot
module lruc_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               step,
    input  lruc_pkg::slot_t    idx,
    input  lruc_pkg::key_t     key,
    input  lruc_pkg::key_t     entry_key,
    input  lruc_pkg::val_t     entry_value,
    input  logic               entry_valid,
    input  lruc_pkg::rank_t    entry_rank,
    output lruc_pkg::scan_res_t res
);

    lruc_pkg::scan_res_t res_reg;
    lruc_pkg::scan_res_t res_next;

    always_comb
    begin
        res_next = res_reg;
        if (clear)
        begin
            res_next.found   = 1'b0;
            res_next.lru_ok  = 1'b0;
            res_next.free_ok = 1'b0;
        end
        else if (step)
        begin
            // keep the first match only
            if (entry_valid && (entry_key == key) && !res_reg.found)
            begin
                res_next.found       = 1'b1;
                res_next.found_idx   = idx;
                res_next.found_rank  = entry_rank;
                res_next.found_value = entry_value;
            end
            if (entry_valid && (!res_reg.lru_ok || (entry_rank > res_reg.lru_rank)))
            begin
                res_next.lru_ok   = 1'b1;
                res_next.lru_idx  = idx;
                res_next.lru_rank = entry_rank;
                res_next.lru_key  = entry_key;
            end
            if (!entry_valid && !res_reg.free_ok)
            begin
                res_next.free_ok  = 1'b1;
                res_next.free_idx = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- src/lru_key_value_cache_unit.sv -----
// LRU key-value cache: sequencer, slot storage and result registers
// The result strobe follows the start transfer after the scan of all slots and the update state.
// A new request is accepted only in idle, after the last one is done: the single compare unit
// visits one slot a cycle, then the update state applies the outcome.
// busy drops in the cycle the result is shown; the receiver cannot stall.
// Reset empties the cache and sets the capacity register to 8.
`include "lru_key_value_cache_unit_macros.svh"

module lru_key_value_cache_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  opcode,
    input  lruc_pkg::key_t        key,
    input  lruc_pkg::val_t        write_value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  lruc_pkg::cfg_t        cfg_data,
    output logic                  result_valid,
    output logic                  hit,
    output lruc_pkg::val_t        read_value,
    output logic                  evicted,
    output lruc_pkg::key_t        evicted_key
);

    lruc_pkg::state_t state_reg;
    lruc_pkg::state_t state_next;
    lruc_pkg::slot_t  idx_reg;
    lruc_pkg::slot_t  idx_next;
    lruc_pkg::cfg_t   cap_reg;
    lruc_pkg::occ_t   occ_reg;
    lruc_pkg::occ_t   occ_next;

    logic             op_reg;
    lruc_pkg::key_t   key_reg;
    lruc_pkg::val_t   wval_reg;

    lruc_pkg::key_t   entry_key_reg   [lruc_pkg::ENTRIES];
    lruc_pkg::val_t   entry_value_reg [lruc_pkg::ENTRIES];
    logic [lruc_pkg::ENTRIES-1:0] valid_reg;
    logic [lruc_pkg::ENTRIES-1:0] valid_next;
    lruc_pkg::rank_t  rank_reg  [lruc_pkg::ENTRIES];
    lruc_pkg::rank_t  rank_next [lruc_pkg::ENTRIES];

    logic             key_we;
    logic             val_we;
    lruc_pkg::slot_t  wr_slot;

    logic             strobe_reg;
    logic             strobe_next;
    logic             hit_reg;
    logic             hit_next;
    lruc_pkg::val_t   rval_reg;
    lruc_pkg::val_t   rval_next;
    logic             evict_reg;
    logic             evict_next;
    lruc_pkg::key_t   ekey_reg;
    lruc_pkg::key_t   ekey_next;

    lruc_pkg::scan_res_t scan;
    lruc_pkg::cmp_t   cap_eff;
    logic             accept;
    logic             do_evict;

    assign accept    = start && (state_reg == lruc_pkg::ST_IDLE);
    assign busy      = (state_reg != lruc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    lruc_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (accept),
        .step        (state_reg == lruc_pkg::ST_SCAN),
        .idx         (idx_reg),
        .key         (key_reg),
        .entry_key   (entry_key_reg[idx_reg]),
        .entry_value (entry_value_reg[idx_reg]),
        .entry_valid (valid_reg[idx_reg]),
        .entry_rank  (rank_reg[idx_reg]),
        .res         (scan)
    );

    // clamp capacity to 1 .. ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = lruc_pkg::cmp_t'(1);
        end
        else if (lruc_pkg::cmp_t'(cap_reg) > lruc_pkg::cmp_t'(lruc_pkg::ENTRIES))
        begin
            cap_eff = lruc_pkg::cmp_t'(lruc_pkg::ENTRIES);
        end
        else
        begin
            cap_eff = lruc_pkg::cmp_t'(cap_reg);
        end
    end

    assign do_evict = (lruc_pkg::cmp_t'(occ_reg) >= cap_eff) && scan.lru_ok;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            lruc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lruc_pkg::ST_SCAN;
                    idx_next   = '0;
                end
            end
            lruc_pkg::ST_SCAN:
            begin
                if (idx_reg == lruc_pkg::LAST_SLOT)
                begin
                    state_next = lruc_pkg::ST_UPDATE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            lruc_pkg::ST_UPDATE:
            begin
                state_next = lruc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lruc_pkg::ST_IDLE;
            end
        endcase
    end

    // apply the outcome of the scan
    always_comb
    begin
        valid_next  = valid_reg;
        rank_next   = rank_reg;
        occ_next    = occ_reg;
        key_we      = 1'b0;
        val_we      = 1'b0;
        wr_slot     = scan.found_idx;
        strobe_next = 1'b0;
        hit_next    = hit_reg;
        rval_next   = rval_reg;
        evict_next  = evict_reg;
        ekey_next   = ekey_reg;
        if (state_reg == lruc_pkg::ST_UPDATE)
        begin
            strobe_next = 1'b1;
            hit_next    = 1'b0;
            rval_next   = '0;
            evict_next  = 1'b0;
            ekey_next   = '0;
            if (scan.found)
            begin
                hit_next = 1'b1;
                if (op_reg == lruc_pkg::OP_GET)
                begin
                    rval_next = scan.found_value;
                end
                else
                begin
                    val_we = 1'b1;
                end
                // promote: younger entries age by one
                for (int i = 0; i < lruc_pkg::ENTRIES; i++)
                begin
                    if (valid_reg[i] && (lruc_pkg::slot_t'(i) != scan.found_idx)
                        && (rank_reg[i] < scan.found_rank))
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[scan.found_idx] = '0;
            end
            else if ((op_reg == lruc_pkg::OP_PUT) && (do_evict || scan.free_ok))
            begin
                wr_slot = do_evict ? scan.lru_idx : scan.free_idx;
                key_we  = 1'b1;
                val_we  = 1'b1;
                if (do_evict)
                begin
                    evict_next = 1'b1;
                    ekey_next  = scan.lru_key;
                end
                else
                begin
                    occ_next = occ_reg + 1'b1;
                end
                for (int i = 0; i < lruc_pkg::ENTRIES; i++)
                begin
                    if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[wr_slot]  = '0;
                valid_next[wr_slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lruc_pkg::ST_IDLE;
            idx_reg    <= '0;
            cap_reg    <= lruc_pkg::CAP_RESET;
            occ_reg    <= '0;
            valid_reg  <= '0;
            strobe_reg <= 1'b0;
            for (int i = 0; i < lruc_pkg::ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            occ_reg    <= occ_next;
            valid_reg  <= valid_next;
            strobe_reg <= strobe_next;
            rank_reg   <= rank_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // payload: request, slot contents and result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            key_reg  <= key;
            wval_reg <= write_value;
        end
        if (key_we)
        begin
            entry_key_reg[wr_slot] <= key_reg;
        end
        if (val_we)
        begin
            entry_value_reg[wr_slot] <= wval_reg;
        end
        hit_reg   <= hit_next;
        rval_reg  <= rval_next;
        evict_reg <= evict_next;
        ekey_reg  <= ekey_next;
    end

    assign result_valid = strobe_reg;
    assign hit          = hit_reg;
    assign read_value   = rval_reg;
    assign evicted      = evict_reg;
    assign evicted_key  = ekey_reg;

    `LRUC_ASSERT_ALWAYS(a_occ_matches_valid, $countones(valid_reg) == occ_reg, "occupancy does not match valid slots")
    `LRUC_ASSERT_IMP(a_strobe_after_update, result_valid, $past(state_reg == lruc_pkg::ST_UPDATE), "result without update cycle")
    `LRUC_ASSERT_IMP(a_evict_not_hit, result_valid && evicted, !hit, "eviction reported on a hit")
    `LRUC_ASSERT_IMP(a_value_needs_hit, result_valid && (read_value != '0), hit, "read value without hit")
    `LRUC_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "start transfer did not raise busy")

endmodule
